// ===== rtl/core/dda_pkg.sv =====
// Shared types, widths and constants for the DDA line rasterizer.
`default_nettype none
package dda_pkg;

   localparam int TILE_BITS = 6;
   localparam int FRAC_BITS = 16;

   // signed Q(TILE_BITS).FRAC_BITS accumulator with one sign bit
   localparam int ACC_W = TILE_BITS + FRAC_BITS + 1;
   // signed Q1.FRAC_BITS slope
   localparam int SLOPE_W = FRAC_BITS + 2;
   // dividend of the slope division, one quotient bit per step
   localparam int DIV_STEPS = TILE_BITS + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int COLOR_W = 32;
   localparam logic [COLOR_W-1:0] COLOR_RESET = {COLOR_W{1'b1}};

   typedef struct packed {
      logic [TILE_BITS-1:0] start_x;
      logic [TILE_BITS-1:0] start_y;
      logic [TILE_BITS-1:0] end_x;
      logic [TILE_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [TILE_BITS-1:0] pixel_x;
      logic [TILE_BITS-1:0] pixel_y;
      logic [COLOR_W-1:0]   pixel_color;
      logic                 last_pixel;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic pixel_step;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic at_end;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/dda_ctrl.sv =====
// Sequencer for the rasterizer: capture, slope division, pixel stepping.
`default_nettype none
module dda_ctrl
   import dda_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      DRAW
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_CNT_W-1:0] count_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = DIV_CNT_W'(DIV_STEPS - 1);
               state_in = DIVIDE;
            end
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            if (count_ff == '0) begin
               state_in = DRAW;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         DRAW: begin
            if (status.out_free) begin
               cmd.pixel_step = 1'b1;
               if (status.at_end) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dda_path.sv =====
// Datapath for the rasterizer: endpoint ordering, serial divider, accumulator, output register.
`default_nettype none
module dda_path
   import dda_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            req_payload,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic               csr_write_enable,
   input  wire logic [COLOR_W-1:0] csr_write_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_payload
);

   localparam logic [TILE_BITS-1:0] TILE_MAX = {TILE_BITS{1'b1}};

   logic [COLOR_W-1:0]            color_ff;
   logic                          steep_ff;
   logic                          neg_ff;
   logic                          zero_ff;
   logic [TILE_BITS-1:0]          major_pos_ff;
   logic [TILE_BITS-1:0]          major_end_ff;
   logic [TILE_BITS-1:0]          divisor_ff;
   logic [TILE_BITS-1:0]          rem_ff;
   logic [DIV_STEPS-1:0]          quot_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff;

   // endpoint ordering
   logic [TILE_BITS-1:0] adx, ady, a0, b0, a1, b1, dmaj, amin;
   logic                 steep, swap, dneg;

   always_comb begin
      adx = (req_payload.end_x > req_payload.start_x) ?
            req_payload.end_x - req_payload.start_x :
            req_payload.start_x - req_payload.end_x;
      ady = (req_payload.end_y > req_payload.start_y) ?
            req_payload.end_y - req_payload.start_y :
            req_payload.start_y - req_payload.end_y;
      steep = ady > adx;
      if (steep) begin
         a0 = req_payload.start_y;
         b0 = req_payload.start_x;
         a1 = req_payload.end_y;
         b1 = req_payload.end_x;
      end else begin
         a0 = req_payload.start_x;
         b0 = req_payload.start_y;
         a1 = req_payload.end_x;
         b1 = req_payload.end_y;
      end
      swap = a1 < a0;
      if (swap) begin
         {a0, a1} = {a1, a0};
         {b0, b1} = {b1, b0};
      end
      dmaj = a1 - a0;
      dneg = b1 < b0;
      amin = dneg ? b0 - b1 : b1 - b0;
   end

   // restoring division step
   logic [TILE_BITS:0]   rem_shift;
   logic                 qbit;
   logic [TILE_BITS-1:0] rem_next;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIV_STEPS-1]};
      qbit = rem_shift >= {1'b0, divisor_ff};
      rem_next = qbit ? TILE_BITS'(rem_shift - {1'b0, divisor_ff}) : rem_shift[TILE_BITS-1:0];
   end

   // signed slope from the quotient
   logic [SLOPE_W-1:0]      mag;
   logic signed [SLOPE_W-1:0] slope;
   logic signed [ACC_W-1:0]   slope_ext;

   always_comb begin
      mag = {1'b0, quot_ff[FRAC_BITS:0]};
      if (zero_ff) begin
         slope = '0;
      end else if (neg_ff) begin
         slope = -$signed(mag);
      end else begin
         slope = $signed(mag);
      end
      slope_ext = {{(ACC_W - SLOPE_W){slope[SLOPE_W-1]}}, slope};
   end

   // round half up, then saturate to the tile
   logic signed [ACC_W:0] rsum;
   logic [TILE_BITS-1:0]  minor;

   always_comb begin
      rsum = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
      if (rsum[ACC_W]) begin
         minor = '0;
      end else if (rsum[ACC_W-1]) begin
         minor = TILE_MAX;
      end else begin
         minor = rsum[FRAC_BITS +: TILE_BITS];
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.at_end   = (major_pos_ff == major_end_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            color_ff <= csr_write_data;
         end
         if (cmd.pixel_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         steep_ff     <= steep;
         neg_ff       <= dneg;
         zero_ff      <= (dmaj == '0);
         major_pos_ff <= a0;
         major_end_ff <= a1;
         divisor_ff   <= dmaj;
         rem_ff       <= '0;
         quot_ff      <= {amin, {FRAC_BITS{1'b0}}} + DIV_STEPS'(dmaj >> 1);
         acc_ff       <= {1'b0, b0, {FRAC_BITS{1'b0}}};
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_next;
         quot_ff <= {quot_ff[DIV_STEPS-2:0], qbit};
      end
      if (cmd.pixel_step) begin
         rsp_ff.pixel_x     <= steep_ff ? minor : major_pos_ff;
         rsp_ff.pixel_y     <= steep_ff ? major_pos_ff : minor;
         rsp_ff.pixel_color <= color_ff;
         rsp_ff.last_pixel  <= status.at_end;
         major_pos_ff       <= major_pos_ff + 1'b1;
         acc_ff             <= acc_ff + slope_ext;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: sequencer plus datapath.
// Operation: a request is taken, the serial slope divider runs to completion, and then
// pixels are drawn one per cycle unless stalled.
// One segment of n pixels (1..64) is handled at a time: the serial divider runs first,
// then the single accumulator steps one pixel per cycle unless stalled.
// Reset: synchronous, active high; returns to idle, drops any pending pixel, color = all ones.
`default_nettype none
module dda_line_rasterizer
   import dda_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // segment requests
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_payload,
   // pixel results
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_payload,
   // color register
   input  wire logic               csr_write_enable,
   input  wire logic [COLOR_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencer: hold off requests while a segment is being divided or drawn.
   // The last pixel sits in the output register, so the next request can be
   // taken while it still waits for the consumer.
   dda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: order endpoints on capture, divide for the slope, then
   // advance the major coordinate and the minor accumulator per pixel.
   dda_path u_path (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== tb/dda_line_rasterizer_tb.sv =====
// Self-checking testbench for the DDA line rasterizer: segment requests in, checked pixels out.
`timescale 1ns / 100ps
module dda_line_rasterizer_tb;
   import dda_pkg::*;

   localparam int TILE_MAX = (1 << TILE_BITS) - 1;
   // cycles with no handshake on either channel before the run is declared hung;
   // the longest legal quiet stretch is the long receiver hold plus one divide
   localparam int STUCK_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 400;
   // let the sequencer settle back to idle after its final pixel
   localparam int SETTLE_CYCLES = 4;
   // margin for the divider and the first pixel
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [COLOR_W-1:0] csr_write_data = '0;

   // pixels predicted for accepted requests, oldest first
   rsp_type pending_pixels[$];
   // local copy of the color register
   logic [COLOR_W-1:0] model_color = COLOR_RESET;
   int mismatch_count = 0;
   int stuck_cycles = 0;
   // receiver hold request, counted down by the stall process
   int hold_cycles_left = 0;
   int stall_burst_left = 0;
   // turn off all random idling for the final stretch
   bit idle_off = 1'b0;

   dda_line_rasterizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void note_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatch_count++;
   endfunction

   // Walk one segment the way the hardware does: pick the major axis, order the
   // endpoints, form the rounded Q1.16 slope once, then step the minor position
   // in fixed point and round it half up for every pixel.
   function automatic void trace_segment(input req_type seg);
      int x0, y0, x1, y1, a0, b0, a1, b1, dmaj, dmin, swap, m, minor;
      bit steep;
      longint mag, slope, acc, rounded;
      rsp_type px;
      x0 = seg.start_x;
      y0 = seg.start_y;
      x1 = seg.end_x;
      y1 = seg.end_y;
      steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
      if (steep) begin
         a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
         a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      // make the major coordinate increase
      if (a1 < a0) begin
         swap = a0; a0 = a1; a1 = swap;
         swap = b0; b0 = b1; b1 = swap;
      end
      dmaj = a1 - a0;
      dmin = b1 - b0;
      // zero-length segment: flat slope, one pixel
      if (dmaj == 0) begin
         slope = 0;
      end else begin
         // ties round away from zero: round the magnitude, then apply the sign
         mag = ((longint'(dmin < 0 ? -dmin : dmin) <<< FRAC_BITS) + dmaj / 2) / dmaj;
         slope = (dmin < 0) ? -mag : mag;
      end
      acc = longint'(b0) <<< FRAC_BITS;
      for (m = a0; m <= a1; m++) begin
         rounded = acc + (longint'(1) <<< (FRAC_BITS - 1));
         // clamp the rounded minor coordinate into the tile
         if (rounded < 0) begin
            minor = 0;
         end else begin
            rounded = rounded >>> FRAC_BITS;
            minor = (rounded > TILE_MAX) ? TILE_MAX : int'(rounded);
         end
         px.pixel_x = steep ? minor[TILE_BITS-1:0] : m[TILE_BITS-1:0];
         px.pixel_y = steep ? m[TILE_BITS-1:0] : minor[TILE_BITS-1:0];
         px.pixel_color = model_color;
         px.last_pixel = (m == a1);
         pending_pixels.push_back(px);
         acc += slope;
      end
   endfunction

   function automatic req_type make_seg(input int x0, input int y0, input int x1, input int y1);
      req_type seg;
      seg.start_x = x0[TILE_BITS-1:0];
      seg.start_y = y0[TILE_BITS-1:0];
      seg.end_x = x1[TILE_BITS-1:0];
      seg.end_y = y1[TILE_BITS-1:0];
      return seg;
   endfunction

   // Mostly full-range segments; a third are short so that many segments finish
   // quickly and the request side sees frequent turnarounds.
   function automatic req_type random_seg();
      int x0, y0, x1, y1;
      x0 = $urandom_range(TILE_MAX, 0);
      y0 = $urandom_range(TILE_MAX, 0);
      if ($urandom_range(2, 0) == 0) begin
         x1 = x0 + $urandom_range(14, 0) - 7;
         y1 = y0 + $urandom_range(14, 0) - 7;
         x1 = (x1 < 0) ? 0 : (x1 > TILE_MAX) ? TILE_MAX : x1;
         y1 = (y1 < 0) ? 0 : (y1 > TILE_MAX) ? TILE_MAX : y1;
      end else begin
         x1 = $urandom_range(TILE_MAX, 0);
         y1 = $urandom_range(TILE_MAX, 0);
      end
      return make_seg(x0, y0, x1, y1);
   endfunction

   // Offer one segment and hold it until taken. Valid stays high on exit unless
   // a random gap follows; the caller drops it through wait_for_drain.
   task automatic offer_segment(input req_type seg);
      req_valid <= 1'b1;
      req_payload <= seg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trace_segment(seg);
      if (!idle_off && $urandom_range(2, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(7, 1)) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every predicted pixel, then let the block go idle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_draw_color(input logic [COLOR_W-1:0] color);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= color;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_color = color;
   endtask

   // ---------------------------------------------------------------- tests

   // The color after reset must be all ones.
   task automatic test_reset_color();
      offer_segment(make_seg(5, 9, 12, 11));
      offer_segment(make_seg(40, 3, 40, 3));
   endtask

   // Extremes, every octant, both slope signs, the steep boundary and rounding ties.
   task automatic test_directed_segments();
      offer_segment(make_seg(0, 0, 0, 0));          // zero length at the origin
      offer_segment(make_seg(63, 63, 63, 63));      // zero length at the far corner
      offer_segment(make_seg(0, 0, 63, 0));         // full horizontal
      offer_segment(make_seg(63, 63, 0, 63));       // horizontal, reversed endpoints
      offer_segment(make_seg(0, 0, 0, 63));         // full vertical
      offer_segment(make_seg(63, 63, 63, 0));       // vertical, reversed
      offer_segment(make_seg(0, 0, 63, 63));        // diagonal: |dy| == |dx| is not steep
      offer_segment(make_seg(63, 0, 0, 63));        // anti-diagonal
      offer_segment(make_seg(0, 0, 62, 63));        // just steep
      offer_segment(make_seg(63, 62, 0, 0));        // shallow, reversed
      offer_segment(make_seg(0, 0, 2, 1));          // positive half-pixel tie
      offer_segment(make_seg(0, 1, 2, 0));          // negative half-pixel tie
      offer_segment(make_seg(1, 0, 0, 2));          // steep tie, negative slope
      offer_segment(make_seg(0, 63, 63, 0));        // falling full span
      offer_segment(make_seg(21, 42, 42, 21));      // alternating bit patterns
      offer_segment(make_seg(42, 21, 21, 42));
      offer_segment(make_seg(0, 0, 63, 1));         // smallest nonzero slope
      offer_segment(make_seg(63, 0, 0, 1));
   endtask

   // Walk the color register through its extremes and alternating patterns.
   task automatic test_color_register();
      logic [COLOR_W-1:0] colors[5];
      colors = '{'0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, COLOR_RESET};
      foreach (colors[i]) begin
         set_draw_color(colors[i]);
         offer_segment(make_seg(3, 60, 10, 50));
         offer_segment(make_seg(7, 7, 7, 7));
      end
   endtask

   // Random segments with random idling on both sides; change color between phases.
   task automatic test_random_segments();
      for (int phase = 0; phase < 4; phase++) begin
         set_draw_color($urandom());
         repeat (24) offer_segment(random_seg());
      end
   endtask

   // Hold off the receiver for a long stretch while requests keep coming, so
   // the block fills up and stalls its input.
   task automatic test_input_backpressure();
      wait_for_drain();
      hold_cycles_left = LONG_HOLD_CYCLES;
      repeat (8) offer_segment(random_seg());
   endtask

   // Final stretch: no idling on either side, requests back to back.
   task automatic test_unbroken_stream();
      wait_for_drain();
      idle_off = 1'b1;
      repeat (20) offer_segment(random_seg());
   endtask

   // ---------------------------------------------------------------- receiver

   // Drive the result stall: a requested long hold first, then random bursts.
   always @(posedge clock) begin
      if (hold_cycles_left > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles_left = hold_cycles_left - 1;
      end else if (stall_burst_left > 0) begin
         rsp_stall <= 1'b1;
         stall_burst_left = stall_burst_left - 1;
      end else if (!idle_off && $urandom_range(3, 0) == 0) begin
         rsp_stall <= 1'b1;
         stall_burst_left = $urandom_range(6, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every accepted pixel against the oldest prediction.
   always @(posedge clock) begin : pixel_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%0b",
               rsp_payload.pixel_x, rsp_payload.pixel_y, rsp_payload.pixel_color,
               rsp_payload.last_pixel));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.pixel_x !== want.pixel_x || rsp_payload.pixel_y !== want.pixel_y ||
                  rsp_payload.pixel_color !== want.pixel_color ||
                  rsp_payload.last_pixel !== want.last_pixel) begin
               note_mismatch($sformatf(
                  "expected x=%0d y=%0d color=%h last=%0b, got x=%0d y=%0d color=%h last=%0b",
                  want.pixel_x, want.pixel_y, want.pixel_color, want.last_pixel,
                  rsp_payload.pixel_x, rsp_payload.pixel_y, rsp_payload.pixel_color,
                  rsp_payload.last_pixel));
            end
         end
      end
   end

   // Watchdog: end the run if no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("dda_line_rasterizer verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_color();
      test_directed_segments();
      test_color_register();
      test_random_segments();
      test_input_backpressure();
      test_unbroken_stream();
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         note_mismatch($sformatf("%0d predicted pixels never arrived", pending_pixels.size()));
      end
      if (mismatch_count == 0) begin
         $display("dda_line_rasterizer verification clean");
      end else begin
         $display("dda_line_rasterizer verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/dda_pkg.sv
rtl/core/dda_ctrl.sv
rtl/core/dda_path.sv
rtl/core/dda_line_rasterizer.sv
tb/dda_line_rasterizer_tb.sv
